// ===== rtl/fs20enc_pkg.sv =====
// ----------------------------------------------------------------------------
// fs20enc_pkg
// Shared types and constants for the chip-level frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fs20enc_pkg;

   // Frame layout.
   localparam int unsigned SYNC_ZEROS = 12;
   localparam int unsigned FIELDS     = 5;
   localparam int unsigned FIELD_BITS = 9;
   localparam int unsigned FRAME_BITS = SYNC_ZEROS + 1 + FIELDS * FIELD_BITS + 1;
   localparam int unsigned BIT_CNT_W  = $clog2(FRAME_BITS);

   // Checksum seed that is added to the four data bytes.
   localparam logic [7:0] CHECK_BASE = 8'd6;

   // Chips per half bit: a one is three on and three off, a zero two and two.
   localparam logic [2:0] CHIPS_ONE  = 3'd3;
   localparam logic [2:0] CHIPS_ZERO = 3'd2;

   // Index of the last checksum step, the one that adds the fourth data byte.
   localparam logic [1:0] LAST_SUM_STEP = 2'd3;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHIP
   } state_type;

   // A data byte followed by its even-parity bit.
   function automatic logic [FIELD_BITS-1:0] field_with_parity(input logic [7:0] b);
      field_with_parity = {b, ^b};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fs20_frame_chip_encoder_core.sv =====
// ----------------------------------------------------------------------------
// fs20_frame_chip_encoder_core
// Builds one on-off-keyed frame per command and delivers it as packed chips.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                          | Direction
//   --------+------------------------------------------------+----------
//   req     | req_valid, req_stall, req_house_code,          | in
//           | req_device_address, req_command_byte           |
//   rsp     | rsp_valid, rsp_stall, rsp_chip_byte,           | out
//           | rsp_last_byte                                  |
//
// A command is accepted while idle, then the checksum takes four steps on a
// single 8-bit adder. The chip packer then makes one chip per cycle while a
// completed byte is not held by an output stall; a frame holds 242 to 318 chips.
// A stalled result beat holds the packer only when the next byte completes.
// Reset is synchronous and returns the sequencer to idle with no beat pending.
// ----------------------------------------------------------------------------
`default_nettype none

module fs20_frame_chip_encoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_house_code,
   input  wire logic [7:0]  req_device_address,
   input  wire logic [7:0]  req_command_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_chip_byte,
   output logic             rsp_last_byte
);

   localparam int unsigned FB = fs20enc_pkg::FRAME_BITS;
   localparam int unsigned BW = fs20enc_pkg::BIT_CNT_W;

   fs20enc_pkg::state_type state_ff, state_in;

   logic [7:0]    hi_ff, lo_ff, addr_ff, cmd_ff;
   logic [7:0]    sum_ff, sum_in;
   logic [1:0]    step_ff, step_in;
   logic [FB-1:0] frame_ff, frame_in;
   logic [BW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [2:0]    chip_cnt_ff, chip_cnt_in;
   logic [7:0]    pack_ff, pack_in;
   logic [2:0]    pack_cnt_ff, pack_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_chip_byte_ff, rsp_chip_byte_in;
   logic          rsp_last_byte_ff, rsp_last_byte_in;

   logic       accept;
   logic       out_free;
   logic [7:0] sum_operand;
   logic [2:0] half_len;
   logic       chip;
   logic       bit_done;
   logic       frame_done;
   logic [7:0] pack_next;
   logic       emit;
   logic       advance;
   logic       sum_last;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Shared adder operand: one data byte per checksum step.
   always_comb begin
      case (step_ff)
         2'd0:    sum_operand = hi_ff;
         2'd1:    sum_operand = lo_ff;
         2'd2:    sum_operand = addr_ff;
         default: sum_operand = cmd_ff;
      endcase
   end
   assign sum_last = (step_ff == fs20enc_pkg::LAST_SUM_STEP);

   // Current frame bit decides the half length; first half is on-chips.
   assign half_len   = frame_ff[FB-1] ? fs20enc_pkg::CHIPS_ONE : fs20enc_pkg::CHIPS_ZERO;
   assign chip       = (chip_cnt_ff < half_len);
   assign bit_done   = (chip_cnt_ff == ((half_len << 1) - 3'd1));
   assign frame_done = bit_done && (bit_cnt_ff == BW'(FB - 1));
   assign pack_next  = pack_ff | ({7'd0, chip} << (3'd7 - pack_cnt_ff));

   // A byte leaves when full or at the frame's final chip.
   assign emit    = (state_ff == fs20enc_pkg::ST_CHIP) &&
                    ((pack_cnt_ff == 3'd7) || frame_done);
   assign advance = (state_ff == fs20enc_pkg::ST_CHIP) && (!emit || out_free);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fs20enc_pkg::ST_IDLE: begin
            if (accept) state_in = fs20enc_pkg::ST_SUM;
         end
         fs20enc_pkg::ST_SUM: begin
            if (sum_last) state_in = fs20enc_pkg::ST_CHIP;
         end
         fs20enc_pkg::ST_CHIP: begin
            if (advance && frame_done) state_in = fs20enc_pkg::ST_IDLE;
         end
         default: state_in = fs20enc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output updates.
   always_comb begin
      sum_in           = sum_ff;
      step_in          = step_ff;
      frame_in         = frame_ff;
      bit_cnt_in       = bit_cnt_ff;
      chip_cnt_in      = chip_cnt_ff;
      pack_in          = pack_ff;
      pack_cnt_in      = pack_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_chip_byte_in = rsp_chip_byte_ff;
      rsp_last_byte_in = rsp_last_byte_ff;
      unique case (state_ff)
         fs20enc_pkg::ST_IDLE: begin
            sum_in      = fs20enc_pkg::CHECK_BASE;
            step_in     = 2'd0;
            bit_cnt_in  = '0;
            chip_cnt_in = '0;
            pack_in     = '0;
            pack_cnt_in = '0;
         end
         fs20enc_pkg::ST_SUM: begin
            sum_in  = sum_ff + sum_operand;
            step_in = step_ff + 2'd1;
            if (sum_last) begin
               frame_in = {{fs20enc_pkg::SYNC_ZEROS{1'b0}}, 1'b1,
                           fs20enc_pkg::field_with_parity(hi_ff),
                           fs20enc_pkg::field_with_parity(lo_ff),
                           fs20enc_pkg::field_with_parity(addr_ff),
                           fs20enc_pkg::field_with_parity(cmd_ff),
                           fs20enc_pkg::field_with_parity(sum_in),
                           1'b0};
            end
         end
         fs20enc_pkg::ST_CHIP: begin
            if (advance) begin
               if (bit_done) begin
                  chip_cnt_in = '0;
                  bit_cnt_in  = bit_cnt_ff + BW'(1);
                  frame_in    = {frame_ff[FB-2:0], 1'b0};
               end else begin
                  chip_cnt_in = chip_cnt_ff + 3'd1;
               end
               if (emit) begin
                  rsp_valid_in     = 1'b1;
                  rsp_chip_byte_in = pack_next;
                  rsp_last_byte_in = frame_done;
                  pack_in          = '0;
                  pack_cnt_in      = '0;
               end else begin
                  pack_in     = pack_next;
                  pack_cnt_in = pack_cnt_ff + 3'd1;
               end
            end
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fs20enc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         hi_ff   <= req_house_code[15:8];
         lo_ff   <= req_house_code[7:0];
         addr_ff <= req_device_address;
         cmd_ff  <= req_command_byte;
      end
      sum_ff           <= sum_in;
      step_ff          <= step_in;
      frame_ff         <= frame_in;
      bit_cnt_ff       <= bit_cnt_in;
      chip_cnt_ff      <= chip_cnt_in;
      pack_ff          <= pack_in;
      pack_cnt_ff      <= pack_cnt_in;
      rsp_chip_byte_ff <= rsp_chip_byte_in;
      rsp_last_byte_ff <= rsp_last_byte_in;
   end

   assign req_stall     = (state_ff != fs20enc_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_chip_byte = rsp_chip_byte_ff;
   assign rsp_last_byte = rsp_last_byte_ff;

   // The chip counter never runs past the end of the current bit.
   a_chip_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fs20enc_pkg::ST_CHIP) |-> (chip_cnt_ff < (half_len << 1)))
      else $error("chip counter beyond bit length");

   // The frame's final beat carries the last flag and frees the sequencer.
   a_last_beat: assert property (@(posedge clock) disable iff (reset)
      (advance && frame_done) |=>
         (rsp_valid_ff && rsp_last_byte_ff && state_ff == fs20enc_pkg::ST_IDLE))
      else $error("final beat not flagged");

   // A new byte never overwrites a beat still waiting at the output.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_chip_byte_ff))
      else $error("pending beat overwritten");

   // An accepted command starts the checksum from its seed.
   a_sum_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == fs20enc_pkg::ST_SUM && step_ff == 2'd0 &&
                  sum_ff == fs20enc_pkg::CHECK_BASE))
      else $error("checksum did not start cleanly");

   // The packer starts every frame empty.
   a_pack_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fs20enc_pkg::ST_SUM) |-> (pack_cnt_ff == 3'd0 && pack_ff == 8'd0))
      else $error("packer not empty at frame start");

endmodule

`default_nettype wire
